// ----- src/aic_pkg.sv -----
// ----------------------------------------------------------------------------
// aic_pkg
// Shared constants, types and GF(2^8) helpers for the AES inverse cipher core.
// ----------------------------------------------------------------------------
package aic_pkg;

  localparam int KEY_STORE_WORDS = 60;
  localparam int KEY_AW          = 6;
  localparam int NR_MIN          = 10;
  localparam int NR_LIMIT        = KEY_STORE_WORDS / 4 - 1;
  localparam int NR_MAX          = (NR_LIMIT < 14) ? NR_LIMIT : 14;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [31:0]  col_t;
  typedef logic [127:0] block_t;

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] k);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 3; i >= 0; i--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h1b : 8'h00);
      if (k[i]) acc = acc ^ a;
    end
    return acc;
  endfunction

  function automatic col_t inv_mix_col(input col_t c);
    logic [7:0] b [4];
    col_t       r;
    for (int i = 0; i < 4; i++) b[i] = c[31-8*i -: 8];
    for (int i = 0; i < 4; i++) begin
      r[31-8*i -: 8] = gf_mul(b[i], 4'd14) ^ gf_mul(b[(i+1)%4], 4'd11) ^
                       gf_mul(b[(i+2)%4], 4'd13) ^ gf_mul(b[(i+3)%4], 4'd9);
    end
    return r;
  endfunction

  function automatic logic [7:0] get_byte(input block_t st, input logic [3:0] idx);
    logic [3:0] pos;
    pos = ~idx;
    return st[{pos, 3'b000} +: 8];
  endfunction

endpackage

// ----- src/aic_if.sv -----
// ----------------------------------------------------------------------------
// aic_if
// Valid/ready channels of the AES inverse cipher core.
// ----------------------------------------------------------------------------
interface aic_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  key_index;
  logic [31:0] key_word;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;

  modport source (output valid, command, key_index, key_word, cipher_hi, cipher_lo,
                  input ready);
  modport sink (input valid, command, key_index, key_word, cipher_hi, cipher_lo,
                output ready);
endinterface

interface aic_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_hi;
  logic [63:0] plain_lo;

  modport source (output valid, plain_hi, plain_lo, input ready);
  modport sink (input valid, plain_hi, plain_lo, output ready);
endinterface

// ----- src/aic_ram.sv -----
// ----------------------------------------------------------------------------
// aic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 60,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/aes_inverse_cipher_core.sv -----
// ----------------------------------------------------------------------------
// aes_inverse_cipher_core
// AES-128/192/256 inverse cipher, one state column per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per handshake: command 0 writes key_word into the
//   round-key store at key_index (ignored at 60 and above), command 1
//   decrypts cipher_hi/cipher_lo. out_o returns one plaintext word per
//   decrypt. cfg_we_i/cfg_wdata_i set the round count (10..14, clamped).
//   A decrypt walks the round keys one column per cycle through the key
//   store read port: 4*(Nr+1) column steps, the last of which registers
//   the result. The core is no longer busy once the result registers.
//   A result waits in the output register while the receiver stalls; a
//   new word is taken once that register is empty or being drained.
//   Reset clears control state and sets Nr to 10; the key store holds no
//   value until it is written.
// ----------------------------------------------------------------------------
module aes_inverse_cipher_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  aic_in_if.sink     in_i,
  aic_out_if.source  out_o
);

  logic [3:0] round_count_q;
  logic       iss_act_q, iss_act_d;
  logic [3:0] iss_rnd_q, iss_rnd_d;
  logic [1:0] iss_col_q, iss_col_d;
  logic [3:0] nr_q, nr_d;
  logic       prc_valid_q;
  logic [3:0] prc_rnd_q;
  logic [1:0] prc_col_q;
  logic       prc_init_q;
  logic       out_valid_q, out_valid_d;
  aic_pkg::block_t st_q, st_d, nxt_q, nxt_d, plain_q, plain_d;

  logic        in_fire, busy, key_we;
  logic [3:0]  nr_clamp;
  aic_pkg::col_t key_col, new_col, sub_col, st_col;
  logic [aic_pkg::KEY_AW-1:0] raddr;
  logic [1:0]  col_pos;

  assign busy       = iss_act_q | prc_valid_q;
  assign in_i.ready = !busy && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign key_we     = in_fire && (in_i.command == aic_pkg::CMD_LOAD) &&
                      (in_i.key_index < 6'(aic_pkg::KEY_STORE_WORDS));
  assign raddr      = {iss_rnd_q, iss_col_q};

  aic_ram #(
    .WIDTH (32),
    .DEPTH (aic_pkg::KEY_STORE_WORDS),
    .AW    (aic_pkg::KEY_AW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (in_i.key_index),
    .wdata_i (in_i.key_word),
    .raddr_i (raddr),
    .rdata_o (key_col)
  );

  always_comb begin
    if (round_count_q < 4'(aic_pkg::NR_MIN)) nr_clamp = 4'(aic_pkg::NR_MIN);
    else if (round_count_q > 4'(aic_pkg::NR_MAX)) nr_clamp = 4'(aic_pkg::NR_MAX);
    else nr_clamp = round_count_q;
  end

  always_comb begin
    logic [1:0] src;
    logic [7:0] sb;
    col_pos = ~prc_col_q;
    st_col  = st_q[{col_pos, 5'b00000} +: 32];
    for (int r = 0; r < 4; r++) begin
      src = prc_col_q - 2'(r);
      sb  = aic_pkg::INV_SBOX[aic_pkg::get_byte(st_q, {src, 2'(r)})];
      sub_col[31-8*r -: 8] = sb ^ key_col[31-8*r -: 8];
    end
    if (prc_init_q) new_col = st_col ^ key_col;
    else if (prc_rnd_q != 4'd0) new_col = aic_pkg::inv_mix_col(sub_col);
    else new_col = sub_col;
  end

  always_comb begin
    iss_act_d   = iss_act_q;
    iss_rnd_d   = iss_rnd_q;
    iss_col_d   = iss_col_q;
    nr_d        = nr_q;
    st_d        = st_q;
    nxt_d       = nxt_q;
    plain_d     = plain_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (in_fire && (in_i.command == aic_pkg::CMD_DECRYPT)) begin
      iss_act_d = 1'b1;
      iss_rnd_d = nr_clamp;
      iss_col_d = 2'd0;
      nr_d      = nr_clamp;
      st_d      = {in_i.cipher_hi, in_i.cipher_lo};
    end
    if (iss_act_q) begin
      iss_col_d = iss_col_q + 2'd1;
      if (iss_col_q == 2'd3) begin
        if (iss_rnd_q == 4'd0) iss_act_d = 1'b0;
        else iss_rnd_d = iss_rnd_q - 4'd1;
      end
    end
    if (prc_valid_q) begin
      if (prc_init_q) begin
        st_d[{col_pos, 5'b00000} +: 32] = new_col;
      end else if (prc_col_q == 2'd3) begin
        st_d = {nxt_q[127:32], new_col};
        if (prc_rnd_q == 4'd0) begin
          plain_d     = {nxt_q[127:32], new_col};
          out_valid_d = 1'b1;
        end
      end else begin
        nxt_d[{col_pos, 5'b00000} +: 32] = new_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= 4'(aic_pkg::NR_MIN);
      iss_act_q     <= 1'b0;
      iss_rnd_q     <= 4'd0;
      iss_col_q     <= 2'd0;
      nr_q          <= 4'(aic_pkg::NR_MIN);
      prc_valid_q   <= 1'b0;
      prc_rnd_q     <= 4'd0;
      prc_col_q     <= 2'd0;
      prc_init_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) round_count_q <= cfg_wdata_i;
      iss_act_q   <= iss_act_d;
      iss_rnd_q   <= iss_rnd_d;
      iss_col_q   <= iss_col_d;
      nr_q        <= nr_d;
      prc_valid_q <= iss_act_q;
      prc_rnd_q   <= iss_rnd_q;
      prc_col_q   <= iss_col_q;
      prc_init_q  <= iss_act_q && (iss_rnd_q == nr_q);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    nxt_q   <= nxt_d;
    plain_q <= plain_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.plain_hi = plain_q[127:64];
  assign out_o.plain_lo = plain_q[63:0];

`ifndef SYNTHESIS
  a_prc_follows_iss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prc_valid_q |-> $past(iss_act_q)) else $error("column step without issue");
  a_decrypt_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.command == aic_pkg::CMD_DECRYPT) |=> iss_act_q)
    else $error("decrypt did not start");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready) else $error("word taken while busy");
`endif

endmodule

// ----- verif/aic_checker.sv -----
// ----------------------------------------------------------------------------
// aic_checker
// Watches the word channels of the inverse cipher core, keeps its own copy of
// the round-key store and round count, predicts each plaintext and compares
// every returned word against the oldest prediction.
// ----------------------------------------------------------------------------
module aic_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  aic_in_if          in_mon,
  aic_out_if         out_mon,
  output int         fail_count_o,
  output int         pending_o
);

  logic [31:0]  key_words [aic_pkg::KEY_STORE_WORDS];
  logic [3:0]   rounds_cfg;
  logic [127:0] plain_q [$];

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] k);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return (k[0] ? a : 8'h00) ^ (k[1] ? a2 : 8'h00) ^ (k[2] ? a4 : 8'h00) ^
           (k[3] ? a8 : 8'h00);
  endfunction

  function automatic logic [127:0] add_key(input logic [127:0] s, input int rnd);
    for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= key_words[4*rnd+c];
    return s;
  endfunction

  function automatic logic [127:0] shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127-8*(r+4*((c+r)%4)) -: 8] = aic_pkg::INV_SBOX[s[127-8*(r+4*c) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] unmix(input logic [127:0] s);
    logic [7:0]   b [4];
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) b[r] = s[127-8*(r+4*c) -: 8];
      for (int r = 0; r < 4; r++)
        t[127-8*(r+4*c) -: 8] = gmul(b[r], 4'd14) ^ gmul(b[(r+1)%4], 4'd11) ^
                                gmul(b[(r+2)%4], 4'd13) ^ gmul(b[(r+3)%4], 4'd9);
    end
    return t;
  endfunction

  function automatic logic [127:0] decrypt_block(input logic [127:0] ct);
    logic [127:0] s;
    int           nr;
    nr = rounds_cfg;
    if (nr < 10) nr = 10;
    if (nr > 14) nr = 14;
    s = add_key(ct, nr);
    for (int rnd = nr - 1; rnd > 0; rnd--) s = unmix(add_key(shift_sub(s), rnd));
    return add_key(shift_sub(s), 0);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want;
    if (!rst_ni) begin
      rounds_cfg   = 4'd10;
      fail_count_o = 0;
      pending_o    = 0;
      plain_q.delete();
    end else begin
      if (cfg_we_i) rounds_cfg = cfg_wdata_i;
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == aic_pkg::CMD_LOAD) begin
          if (in_mon.key_index < aic_pkg::KEY_STORE_WORDS)
            key_words[in_mon.key_index] = in_mon.key_word;
        end else begin
          plain_q.push_back(decrypt_block({in_mon.cipher_hi, in_mon.cipher_lo}));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected word hi=%h lo=%h", $time, out_mon.plain_hi,
                   out_mon.plain_lo);
          fail_count_o++;
        end else begin
          want = plain_q.pop_front();
          if (out_mon.plain_hi !== want[127:64]) begin
            $display("%0t: plain_hi expected %h actual %h", $time, want[127:64],
                     out_mon.plain_hi);
            fail_count_o++;
          end
          if (out_mon.plain_lo !== want[63:0]) begin
            $display("%0t: plain_lo expected %h actual %h", $time, want[63:0],
                     out_mon.plain_lo);
            fail_count_o++;
          end
        end
      end
      pending_o = plain_q.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives load and decrypt words into the inverse cipher core across several
// round counts and idle/stall mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  int         idle_pct;
  int         stall_pct;
  int         fails;
  int         pending;

  aic_in_if  in_ch ();
  aic_out_if out_ch ();

  aes_inverse_cipher_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source)
  );

  aic_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic cmd, input logic [5:0] idx, input logic [31:0] kw,
                           input logic [63:0] hi, input logic [63:0] lo);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat (1 + $urandom_range(3)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.key_index <= idx;
    in_ch.key_word  <= kw;
    in_ch.cipher_hi <= hi;
    in_ch.cipher_lo <= lo;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic set_rounds(input logic [3:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [3:0] settings [7] = '{4'd0, 4'd15, 4'd11, 4'd12, 4'd13, 4'd14, 4'd10};
    int         idles [4]    = '{0, 67, 0, 16};
    int         stalls [4]   = '{0, 0, 67, 16};
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 4'd0;
    idle_pct        = 0;
    stall_pct       = 0;
    in_ch.valid     = 1'b0;
    in_ch.command   = aic_pkg::CMD_LOAD;
    in_ch.key_index = '0;
    in_ch.key_word  = '0;
    in_ch.cipher_hi = '0;
    in_ch.cipher_lo = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_rounds(4'd10);
    for (int i = 0; i < aic_pkg::KEY_STORE_WORDS; i++)
      send_word(aic_pkg::CMD_LOAD, 6'(i), (i % 2) ? $urandom() : ~32'h0, '0, '0);
    for (int i = aic_pkg::KEY_STORE_WORDS; i < 64; i++)
      send_word(aic_pkg::CMD_LOAD, 6'(i), '0, '0, '0);
    send_word(aic_pkg::CMD_DECRYPT, 6'h3f, '0, '0, '0);
    send_word(aic_pkg::CMD_DECRYPT, '0, '0, ~64'h0, ~64'h0);
    send_word(aic_pkg::CMD_DECRYPT, '0, '0, 64'h5555_5555_5555_5555,
              64'haaaa_aaaa_aaaa_aaaa);
    send_word(aic_pkg::CMD_DECRYPT, '0, '0, {$urandom(), $urandom()},
              {$urandom(), $urandom()});
    foreach (settings[s]) begin
      set_rounds(settings[s]);
      for (int p = 0; p < 4; p++) begin
        idle_pct  = idles[p];
        stall_pct = stalls[p];
        if (p == 2) drain();
        repeat (12) begin
          if ($urandom_range(1))
            send_word(aic_pkg::CMD_DECRYPT, 6'($urandom()), $urandom(),
                      {$urandom(), $urandom()}, {$urandom(), $urandom()});
          else
            send_word(aic_pkg::CMD_LOAD, 6'($urandom_range(63)), $urandom(),
                      {$urandom(), $urandom()}, {$urandom(), $urandom()});
        end
      end
    end
    drain();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
